[rtl/lpd_pkg.sv]
package lpd_pkg;

  localparam int unsigned PACKET_BYTES = 47;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned ACC_W        = 17;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned OUT_DATA_W   = 88;

  localparam logic [ACC_W-1:0] ANGLE_WRAP   = 17'd36000;
  localparam logic [ACC_W-1:0] ANGLE_WRAP_2 = 17'd72000;

  localparam logic [POS_W-1:0] POS_HUNT     = 6'd0;
  localparam logic [POS_W-1:0] POS_VERLEN   = 6'd1;
  localparam logic [POS_W-1:0] POS_BODY     = 6'd2;
  localparam logic [POS_W-1:0] POS_SPEED_LO = 6'd2;
  localparam logic [POS_W-1:0] POS_SPEED_HI = 6'd3;
  localparam logic [POS_W-1:0] POS_START_LO = 6'd4;
  localparam logic [POS_W-1:0] POS_START_HI = 6'd5;
  localparam logic [POS_W-1:0] POS_PTS_FIRST = 6'd6;
  localparam logic [POS_W-1:0] POS_PTS_LAST  = 6'd41;
  localparam logic [POS_W-1:0] POS_END_LO   = 6'd42;
  localparam logic [POS_W-1:0] POS_END_HI   = 6'd43;
  localparam logic [POS_W-1:0] POS_STAMP_LO = 6'd44;
  localparam logic [POS_W-1:0] POS_STAMP_HI = 6'd45;
  localparam logic [POS_W-1:0] POS_CHECK    = 6'd46;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h54;
  localparam logic [BYTE_W-1:0] VERLEN_RESET = 8'h2C;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER = 1'b0,
    REG_VERLEN = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             byte_we;
    logic [POS_W-1:0] pos;
    logic             div_init;
    logic             div_step;
    logic             acc_init;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             load_out;
    logic             last;
  } lpd_cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic vl_match;
    logic out_busy;
    logic out_fire;
  } lpd_status_t;

endpackage

[rtl/lpd_datapath.sv]
module lpd_datapath #(
  parameter int unsigned POINTS_PER_PACKET = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lpd_pkg::BYTE_W-1:0]       cfg_data_i,
  input  logic [lpd_pkg::BYTE_W-1:0]       rx_byte_i,
  input  lpd_pkg::lpd_cmd_t                cmd_i,
  output lpd_pkg::lpd_status_t             status_o,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [lpd_pkg::OUT_DATA_W-1:0]   m_tdata_o,
  output logic                             m_tlast_o
);
  import lpd_pkg::*;

  localparam int unsigned MEM_AW = $clog2(POINTS_PER_PACKET);
  localparam int unsigned DIV_W  = $clog2(POINTS_PER_PACKET);
  localparam logic [DIV_W-1:0] DIVISOR = DIV_W'(POINTS_PER_PACKET - 1);
  localparam logic [IDX_W-1:0] NUM_PTS = IDX_W'(POINTS_PER_PACKET);
  localparam int unsigned PT_W = WORD_W + BYTE_W;
  localparam int unsigned QSHIFT  = WORD_W + DIV_W;
  localparam int unsigned RECIP_W = WORD_W + 2;
  localparam int unsigned PROD_W  = WORD_W + RECIP_W;
  localparam longint unsigned DIV_VAL   = longint'(POINTS_PER_PACKET - 1);
  localparam longint unsigned RECIP_VAL = ((64'd1 << QSHIFT) + DIV_VAL - 64'd1) / DIV_VAL;
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_VAL);

  typedef enum logic [1:0] {
    LANE_LO,
    LANE_HI,
    LANE_INT
  } lane_e;

  logic [BYTE_W-1:0] header_q, verlen_q;
  logic [WORD_W-1:0] speed_q, start_q, end_q, stamp_q;
  logic [BYTE_W-1:0] check_q, dist_lo_q, dist_hi_q;
  lane_e             lane_q, lane_cur;
  logic [IDX_W-1:0]  wr_idx_q, wr_idx_cur;
  logic [PT_W-1:0]   mem_q [POINTS_PER_PACKET];
  logic [PT_W-1:0]   rd_data_q;

  logic              neg_q;
  logic [WORD_W-1:0] dq_q, quot_q;
  logic [DIV_W-1:0]  sr_q, accr_q;
  logic [ACC_W-1:0]  sq_q, acc_q;

  logic                  out_valid_q, out_last_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [ACC_W-1:0]  delta;
  logic              delta_pos;
  logic [ACC_W:0]    span;
  logic [ACC_W:0]    span_abs;
  logic [WORD_W-1:0] span_mag;
  logic [PROD_W-1:0] prod;
  logic [WORD_W-1:0] quot_full;
  logic [DIV_W-1:0]  rem_lo;
  logic [ACC_W-1:0]  q0, sq_init;
  logic              rem_nz;
  logic [DIV_W-1:0]  sr_init;
  logic [DIV_W:0]    r_sum;
  logic              carry;
  logic [DIV_W-1:0]  accr_nx;
  logic [ACC_W-1:0]  acc_nx, angle_full;
  logic              in_points;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RESET;
      verlen_q <= VERLEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HEADER: header_q <= cfg_data_i;
        REG_VERLEN: verlen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_points  = (cmd_i.pos inside {[POS_PTS_FIRST:POS_PTS_LAST]});
  assign lane_cur   = (cmd_i.pos == POS_PTS_FIRST) ? LANE_LO : lane_q;
  assign wr_idx_cur = (cmd_i.pos == POS_PTS_FIRST) ? '0 : wr_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_we) begin
      case (cmd_i.pos)
        POS_SPEED_LO: speed_q[7:0]  <= rx_byte_i;
        POS_SPEED_HI: speed_q[15:8] <= rx_byte_i;
        POS_START_LO: start_q[7:0]  <= rx_byte_i;
        POS_START_HI: start_q[15:8] <= rx_byte_i;
        POS_END_LO:   end_q[7:0]    <= rx_byte_i;
        POS_END_HI:   end_q[15:8]   <= rx_byte_i;
        POS_STAMP_LO: stamp_q[7:0]  <= rx_byte_i;
        POS_STAMP_HI: stamp_q[15:8] <= rx_byte_i;
        POS_CHECK:    check_q       <= rx_byte_i;
        default: ;
      endcase
      if (in_points) begin
        case (lane_cur)
          LANE_LO: begin
            dist_lo_q <= rx_byte_i;
            lane_q    <= LANE_HI;
            wr_idx_q  <= wr_idx_cur;
          end
          LANE_HI: begin
            dist_hi_q <= rx_byte_i;
            lane_q    <= LANE_INT;
          end
          default: begin
            if (wr_idx_cur < NUM_PTS) begin
              mem_q[wr_idx_cur[MEM_AW-1:0]] <= {rx_byte_i, dist_hi_q, dist_lo_q};
            end
            lane_q   <= LANE_LO;
            wr_idx_q <= wr_idx_cur + 1'b1;
          end
        endcase
      end
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cmd_i.rd_idx[MEM_AW-1:0]];
    end
  end

  // The span is signed: a wrap with a large start angle can make it negative,
  // so the quotient is taken on its magnitude and floored afterwards.
  always_comb begin
    delta     = {1'b0, end_q} - {1'b0, start_q};
    delta_pos = !delta[ACC_W-1] && (delta != '0);
    span      = delta_pos ? {delta[ACC_W-1], delta}
                          : ({delta[ACC_W-1], delta} + (ACC_W+1)'(ANGLE_WRAP));
    span_abs  = -span;
    span_mag  = span[ACC_W] ? span_abs[WORD_W-1:0] : span[WORD_W-1:0];

    prod      = dq_q * RECIP;
    quot_full = WORD_W'(prod >> QSHIFT);
    rem_lo    = dq_q[DIV_W-1:0] - quot_q[DIV_W-1:0] * DIVISOR;

    q0      = {1'b0, quot_q};
    rem_nz  = (rem_lo != '0);
    sq_init = neg_q ? (-q0 - ACC_W'(rem_nz)) : q0;
    sr_init = (neg_q && rem_nz) ? (DIVISOR - rem_lo) : rem_lo;

    r_sum   = {1'b0, accr_q} + {1'b0, sr_q};
    carry   = (r_sum >= {1'b0, DIVISOR});
    accr_nx = carry ? DIV_W'(r_sum - {1'b0, DIVISOR}) : r_sum[DIV_W-1:0];
    acc_nx  = acc_q + sq_q + ACC_W'(carry);

    if (acc_q >= ANGLE_WRAP_2) begin
      angle_full = acc_q - ANGLE_WRAP_2;
    end else if (acc_q >= ANGLE_WRAP) begin
      angle_full = acc_q - ANGLE_WRAP;
    end else begin
      angle_full = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q <= span[ACC_W];
      dq_q  <= span_mag;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_full;
    end
    if (cmd_i.acc_init) begin
      sq_q   <= sq_init;
      sr_q   <= sr_init;
      acc_q  <= {1'b0, start_q};
      accr_q <= '0;
    end else if (cmd_i.load_out) begin
      acc_q  <= acc_nx;
      accr_q <= accr_nx;
    end
    if (cmd_i.load_out) begin
      out_data_q <= {4'b0, check_q, stamp_q, speed_q, rd_data_q[PT_W-1:WORD_W],
                     rd_data_q[WORD_W-1:0], angle_full[WORD_W-1:0], cmd_i.rd_idx};
      out_last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

  assign status_o.hdr_match = (rx_byte_i == header_q);
  assign status_o.vl_match  = (rx_byte_i == verlen_q);
  assign status_o.out_busy  = out_valid_q;
  assign status_o.out_fire  = out_valid_q && m_tready_i;

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[19:4] < ANGLE_WRAP[WORD_W-1:0]))
    else $error("point angle out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !out_valid_q)
    else $error("result loaded over a pending result");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_init |-> (rem_lo < DIVISOR))
    else $error("span remainder not below divisor");

endmodule

[rtl/lpd_ctrl.sv]
module lpd_ctrl #(
  parameter int unsigned POINTS_PER_PACKET = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  lpd_pkg::lpd_status_t status_i,
  output lpd_pkg::lpd_cmd_t    cmd_o
);
  import lpd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_PACKET - 1);

  typedef enum logic [2:0] {
    ST_RECV,
    ST_DIV,
    ST_INIT,
    ST_RD,
    ST_LD,
    ST_WAIT
  } state_e;

  state_e           state_q;
  logic [POS_W-1:0] pos_q;
  logic [IDX_W-1:0] emit_idx_q;
  logic             s_fire;

  assign s_tready_o = (state_q == ST_RECV);
  assign s_fire     = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RECV;
      pos_q      <= POS_HUNT;
      emit_idx_q <= '0;
    end else begin
      case (state_q)
        ST_RECV: begin
          if (s_fire) begin
            case (pos_q)
              POS_HUNT: begin
                if (status_i.hdr_match) pos_q <= POS_VERLEN;
              end
              POS_VERLEN: begin
                if (status_i.vl_match) begin
                  pos_q <= POS_BODY;
                end else if (!status_i.hdr_match) begin
                  pos_q <= POS_HUNT;
                end
              end
              POS_CHECK: begin
                pos_q   <= POS_HUNT;
                state_q <= ST_DIV;
              end
              default: pos_q <= pos_q + 1'b1;
            endcase
          end
        end
        ST_DIV: state_q <= ST_INIT;
        ST_INIT: begin
          emit_idx_q <= '0;
          state_q    <= ST_RD;
        end
        ST_RD: state_q <= ST_LD;
        ST_LD: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (status_i.out_fire) begin
            if (emit_idx_q == LAST_IDX) begin
              emit_idx_q <= '0;
              state_q    <= ST_RECV;
            end else begin
              emit_idx_q <= emit_idx_q + 1'b1;
              state_q    <= ST_RD;
            end
          end
        end
        default: state_q <= ST_RECV;
      endcase
    end
  end

  always_comb begin
    cmd_o.byte_we  = s_fire && (pos_q >= POS_BODY);
    cmd_o.pos      = pos_q;
    cmd_o.div_init = s_fire && (pos_q == POS_CHECK);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.acc_init = (state_q == ST_INIT);
    cmd_o.rd_en    = (state_q == ST_RD);
    cmd_o.rd_idx   = emit_idx_q;
    cmd_o.load_out = (state_q == ST_LD);
    cmd_o.last     = (emit_idx_q == LAST_IDX);
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < POS_W'(PACKET_BYTES))
    else $error("byte position beyond packet");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_idx_q <= LAST_IDX)
    else $error("point index beyond packet");

  a_recv_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !status_i.out_busy)
    else $error("receiving while a point is still pending");

endmodule

[rtl/lidar_packet_deframer.sv]
// Bytes are accepted one per cycle while a packet is being collected.
// After the final byte, a divide state divides the span by a reciprocal multiply and
// a setup state runs, then each point passes through read, load and wait states,
// the wait state holding until the output takes the point.
// Reset is asynchronous active low; it restarts the header hunt, drops any
// pending point and restores the sync bytes to 0x54 and 0x2C.
module lidar_packet_deframer #(
  parameter int unsigned POINTS_PER_PACKET = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lpd_pkg::BYTE_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // rx_byte [7:0]
  input  logic [lpd_pkg::BYTE_W-1:0]     s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // point_index [3:0], point_angle [19:4], point_distance [35:20],
  // point_intensity [43:36], scan_speed [59:44], packet_time [75:60],
  // check_byte [83:76], zero [87:84]
  output logic [lpd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import lpd_pkg::*;

  lpd_cmd_t    cmd;
  lpd_status_t status;

  lpd_ctrl #(
    .POINTS_PER_PACKET(POINTS_PER_PACKET)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lpd_datapath #(
    .POINTS_PER_PACKET(POINTS_PER_PACKET)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_byte_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule
